// ----- rtl/fphole_pkg.sv -----
`timescale 1ns / 1ps
package fphole_pkg;

   localparam int HOLES  = 256;
   localparam int AW     = $clog2(HOLES);
   localparam int CW     = $clog2(HOLES + 1);
   localparam int SIZE_W = 16;
   localparam int OFF_W  = 32;
   localparam int MODE_W = 2;

   typedef logic [AW-1:0]     addr_type;
   typedef logic [CW-1:0]     count_type;
   typedef logic [SIZE_W-1:0] size_type;
   typedef logic [OFF_W-1:0]  offset_type;
   typedef logic [MODE_W-1:0] mode_type;

   typedef struct packed {
      size_type   size;
      offset_type offset;
   } hole_type;

   localparam int HOLE_W = $bits(hole_type);

   typedef enum logic [1:0] {
      ST_REUSED   = 2'd0,
      ST_APPENDED = 2'd1,
      ST_FREED    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam mode_type FIT_FIRST = 2'd0;
   localparam mode_type FIT_BEST  = 2'd1;
   localparam mode_type FIT_WORST = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_DROP,
      S_SEEK,
      S_LIFT,
      S_PUT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       valid;
      status_type status;
      offset_type place_offset;
      count_type  holes_now;
   } result_type;

endpackage

// ----- rtl/fphole_if.sv -----
`timescale 1ns / 1ps
interface fphole_req_if;
   import fphole_pkg::*;
   logic       valid;
   logic       ready;
   logic       cmd;
   size_type   req_size;
   offset_type free_offset;
   modport source(output valid, cmd, req_size, free_offset, input ready);
   modport sink(input valid, cmd, req_size, free_offset, output ready);
endinterface

interface fphole_rsp_if;
   import fphole_pkg::*;
   logic       valid;
   logic       ready;
   status_type status;
   offset_type place_offset;
   count_type  holes_now;
   modport source(output valid, status, place_offset, holes_now, input ready);
   modport sink(input valid, status, place_offset, holes_now, output ready);
endinterface

interface fphole_csr_if;
   import fphole_pkg::*;
   logic     valid;
   logic     ready;
   mode_type fit_mode;
   modport source(output valid, fit_mode, input ready);
   modport sink(input valid, fit_mode, output ready);
endinterface

// ----- rtl/fphole_ram.sv -----
`timescale 1ns / 1ps
module fphole_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one word, read one word registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/fphole_ctrl.sv -----
`timescale 1ns / 1ps
module fphole_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  fphole_pkg::mode_type   fit_mode,
   input  logic                   start,
   input  logic                   cmd,
   input  fphole_pkg::size_type   req_size,
   input  fphole_pkg::offset_type free_offset,
   output logic                   idle,
   output fphole_pkg::result_type result,
   input  logic                   take
);
   import fphole_pkg::*;

   state_type  state_ff, state_in;
   count_type  ptr_ff, ptr_in;
   addr_type   chk_ff, chk_in;
   logic       pend_ff, pend_in;
   count_type  pos_ff, pos_in;
   count_type  count_ff, count_in;
   offset_type end_ff, end_in;
   size_type   size_ff, size_in;
   hole_type   fnd_ff, fnd_in;
   hole_type   new_ff, new_in;
   offset_type place_ff, place_in;
   status_type status_ff, status_in;

   logic     wr_en;
   addr_type wr_addr;
   hole_type wr_data;
   addr_type rd_addr;
   hole_type rd_hole;
   logic [HOLE_W-1:0] rd_raw;

   logic more, find_hit, find_miss, ahead, seek_hit, seek_tail;
   logic drop_end, lift_more, lift_end, remainder;

   fphole_ram #(.WIDTH(HOLE_W), .DEPTH(HOLES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );
   assign rd_hole = rd_raw;

   // scan conditions on the word read last cycle
   assign more      = ptr_ff < count_ff;
   assign find_hit  = pend_ff && (rd_hole.size >= size_ff);
   assign find_miss = !find_hit && !more;
   assign ahead     = ((fit_mode == FIT_BEST) && (new_ff.size < rd_hole.size)) ||
                      ((fit_mode == FIT_WORST) && (new_ff.size > rd_hole.size));
   assign seek_hit  = pend_ff && ahead;
   assign seek_tail = !seek_hit && !more;
   assign drop_end  = !pend_ff && !more;
   assign lift_more = ptr_ff > pos_ff;
   assign lift_end  = !pend_ff && !lift_more;
   assign remainder = (fnd_ff.size > size_ff) || (size_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (cmd == CMD_ALLOC) begin
                  state_in = S_FIND;
               end else if (count_ff >= count_type'(HOLES)) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_SEEK;
               end
            end
         end
         S_FIND: begin
            if (find_hit) begin
               state_in = S_DROP;
            end else if (find_miss) begin
               state_in = S_DONE;
            end
         end
         S_DROP: begin
            if (drop_end) begin
               state_in = remainder ? S_SEEK : S_DONE;
            end
         end
         S_SEEK: begin
            if (seek_hit || seek_tail) begin
               state_in = S_LIFT;
            end
         end
         S_LIFT: begin
            if (lift_end) begin
               state_in = S_PUT;
            end
         end
         S_PUT:  state_in = S_DONE;
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory access
   always_comb begin
      ptr_in    = ptr_ff;
      chk_in    = chk_ff;
      pend_in   = pend_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      end_in    = end_ff;
      size_in   = size_ff;
      fnd_in    = fnd_ff;
      new_in    = new_ff;
      place_in  = place_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = rd_hole;
      rd_addr   = ptr_ff[AW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            ptr_in  = '0;
            pend_in = 1'b0;
            if (start) begin
               size_in  = req_size;
               new_in   = '{size: req_size, offset: free_offset};
               place_in = '0;
               if (cmd == CMD_FREE) begin
                  status_in = (count_ff >= count_type'(HOLES)) ? ST_FULL : ST_FREED;
               end
            end
         end
         S_FIND: begin
            // fetch next entry while checking the last one
            if (more) begin
               chk_in  = ptr_ff[AW-1:0];
               pend_in = 1'b1;
               ptr_in  = ptr_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (find_hit) begin
               fnd_in    = rd_hole;
               place_in  = rd_hole.offset;
               status_in = ST_REUSED;
               ptr_in    = count_type'(chk_ff) + 1'b1;
               pend_in   = 1'b0;
            end else if (find_miss) begin
               place_in  = end_ff;
               end_in    = end_ff + offset_type'(size_ff);
               status_in = ST_APPENDED;
            end
         end
         S_DROP: begin
            // move entries above the taken hole down by one
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = chk_ff - 1'b1;
            end
            if (more) begin
               chk_in  = ptr_ff[AW-1:0];
               pend_in = 1'b1;
               ptr_in  = ptr_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (drop_end) begin
               count_in = count_ff - 1'b1;
               new_in   = '{size: fnd_ff.size - size_ff,
                            offset: fnd_ff.offset + offset_type'(size_ff)};
               ptr_in   = '0;
               pend_in  = 1'b0;
            end
         end
         S_SEEK: begin
            if (more) begin
               chk_in  = ptr_ff[AW-1:0];
               pend_in = 1'b1;
               ptr_in  = ptr_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (seek_hit || seek_tail) begin
               pos_in  = seek_hit ? count_type'(chk_ff) : count_ff;
               ptr_in  = count_ff;
               pend_in = 1'b0;
            end
         end
         S_LIFT: begin
            // move entries at and above the slot up by one, top first
            rd_addr = addr_type'(ptr_ff - 1'b1);
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = chk_ff + 1'b1;
            end
            if (lift_more) begin
               chk_in  = addr_type'(ptr_ff - 1'b1);
               pend_in = 1'b1;
               ptr_in  = ptr_ff - 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff[AW-1:0];
            wr_data  = new_ff;
            count_in = count_ff + 1'b1;
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         count_ff <= '0;
         end_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         count_ff <= count_in;
         end_ff   <= end_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      chk_ff    <= chk_in;
      pos_ff    <= pos_in;
      size_ff   <= size_in;
      fnd_ff    <= fnd_in;
      new_ff    <= new_in;
      place_ff  <= place_in;
      status_ff <= status_in;
   end

   assign idle                = state_ff == S_IDLE;
   assign result.valid        = state_ff == S_DONE;
   assign result.status       = status_ff;
   assign result.place_offset = place_ff;
   assign result.holes_now    = count_ff;
endmodule

// ----- rtl/fit_policy_hole_allocator.sv -----
`timescale 1ns / 1ps
// Word taken to result valid: allocate from a hole scans, shifts the entries above it
// down and, for a remainder, scans, shifts up and writes it; free scans, shifts up and
// writes; allocate at the end pointer only scans; free into a full table skips all steps.
// One word in flight; the next word is taken in the cycle after the result moves to
// the output register, where it waits for the receiver.
// Reset (synchronous, active high) clears hole count, end pointer and fit mode;
// hole RAM contents are not cleared.
module fit_policy_hole_allocator (
   input logic          clock,
   input logic          reset,
   fphole_req_if.sink   req_port,
   fphole_rsp_if.source rsp_port,
   fphole_csr_if.sink   csr_port
);
   import fphole_pkg::*;

   mode_type   mode_ff;
   logic       idle;
   logic       take;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type result;
   result_type rsp_ff;

   fphole_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .fit_mode    (mode_ff),
      .start       (req_port.valid && idle),
      .cmd         (req_port.cmd),
      .req_size    (req_port.req_size),
      .free_offset (req_port.free_offset),
      .idle        (idle),
      .result      (result),
      .take        (take)
   );

   assign req_port.ready = idle;
   assign csr_port.ready = 1'b1;

   // load output register when empty or draining
   assign take         = result.valid && (!rsp_valid_ff || rsp_port.ready);
   assign rsp_valid_in = take ? 1'b1 : (rsp_port.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= FIT_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_port.valid) begin
            mode_ff <= csr_port.fit_mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= result;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.status       = rsp_ff.status;
   assign rsp_port.place_offset = rsp_ff.place_offset;
   assign rsp_port.holes_now    = rsp_ff.holes_now;
endmodule
